FILE: sv/bis_pkg.sv
// ----------------------------------------------------------------------------
// Bounded integer sorter package
// Shared widths, defaults and the control types that pass between the
// sequencer and the cell chain.
// ----------------------------------------------------------------------------
package bis_pkg;

  // Width of one stored value.
  localparam int VALUE_W = 31;

  // Default capacity of the cell chain.
  localparam int MAX_ELEMENTS_DEF = 64;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the broadcast value in order
    logic shift;   // move every entry one cell toward the head
  } chain_cmd_t;

  // Status that the chain reports to the sequencer.
  typedef struct packed {
    logic full;       // the tail cell holds a value
    logic head_last;  // the head cell holds the final value of the run
  } chain_status_t;

endpackage

FILE: sv/bis_in_if.sv
// ----------------------------------------------------------------------------
// Input channel
// Carries one value of the set and its last flag per transaction.
// ----------------------------------------------------------------------------
interface bis_in_if;

  logic                        valid;
  logic                        ready;
  logic [bis_pkg::VALUE_W-1:0] value;
  logic                        last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);

endinterface

FILE: sv/bis_out_if.sv
// ----------------------------------------------------------------------------
// Output channel
// Carries one sorted value with its run flags per transaction.
// ----------------------------------------------------------------------------
interface bis_out_if;

  logic                        valid;
  logic                        ready;
  logic [bis_pkg::VALUE_W-1:0] sorted_value;
  logic                        end_of_run;
  logic                        overflow;

  modport source (output valid, output sorted_value, output end_of_run,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input end_of_run,
                  input overflow, output ready);

endinterface

FILE: sv/bis_cell.sv
// ----------------------------------------------------------------------------
// Sorter cell
// One entry of the insertion chain. On insert it keeps its value, takes the
// new value, or takes its left neighbor's value; on shift it takes its right
// neighbor's value.
// ----------------------------------------------------------------------------
module bis_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  bis_pkg::chain_cmd_t         cmd,
  input  logic [bis_pkg::VALUE_W-1:0] value_in,
  input  logic [bis_pkg::VALUE_W-1:0] left_value,
  input  logic                        left_valid,
  input  logic                        left_gt,
  input  logic [bis_pkg::VALUE_W-1:0] right_value,
  input  logic                        right_valid,
  output logic [bis_pkg::VALUE_W-1:0] value,
  output logic                        valid,
  output logic                        gt
);

  logic first_empty;
  logic take;

  // A strictly greater entry moves right, so equal values keep arrival order.
  assign gt          = valid && (value > value_in);
  assign first_empty = !valid && left_valid;
  assign take        = cmd.insert && (gt || first_empty);

  // Occupancy flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.shift) begin
      valid <= right_valid;
    end else if (take) begin
      valid <= 1'b1;
    end
  end

  // Stored value.
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      value <= right_value;
    end else if (take) begin
      value <= left_gt ? left_value : value_in;
    end
  end

endmodule

FILE: sv/bis_ctrl.sv
// ----------------------------------------------------------------------------
// Sorter sequencer
// Switches between collecting a set and draining it, and tracks whether any
// value of the current set was dropped.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_fire,
  input  logic                   in_last,
  input  logic                   out_fire,
  input  bis_pkg::chain_status_t status,
  output bis_pkg::chain_cmd_t    cmd,
  output logic                   in_ready,
  output logic                   draining,
  output logic                   dropped
);

  typedef enum logic {
    COLLECT,
    DRAIN
  } state_t;

  state_t state;

  assign in_ready   = (state == COLLECT);
  assign draining   = (state == DRAIN);
  assign cmd.insert = in_fire && !status.full;
  assign cmd.shift  = out_fire;

  // State and drop flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= COLLECT;
      dropped <= 1'b0;
    end else begin
      case (state)
        COLLECT: begin
          if (in_fire) begin
            if (status.full) begin
              dropped <= 1'b1;
            end
            if (in_last) begin
              state <= DRAIN;
            end
          end
        end
        DRAIN: begin
          if (out_fire && status.head_last) begin
            state   <= COLLECT;
            dropped <= 1'b0;
          end
        end
        default: begin
          state <= COLLECT;
        end
      endcase
    end
  end

endmodule

FILE: sv/bounded_integer_sorter.sv
// ----------------------------------------------------------------------------
// Bounded integer sorter
// Collects a set of values and returns it in ascending order.
// ----------------------------------------------------------------------------
// The feed channel takes one value per transaction; the transaction with
// last set closes the set. Each value is placed in order on arrival by a
// chain of MAX_ELEMENTS cells, so the open feed takes one transaction per cycle.
// Values that arrive while every cell is occupied are dropped and the run
// is marked with overflow.
// After the closing transaction the chain drains through the head cell:
// the first result is offered in the next cycle, then one result per cycle
// while the receiver is ready, with end_of_run on the final one and the
// same overflow flag on each. The feed is held off from the closing
// transaction until the final result is taken. A stalled receiver simply
// freezes the chain; nothing is lost.
// Reset empties the chain, clears the overflow flag and opens the feed.
// ----------------------------------------------------------------------------
module bounded_integer_sorter #(
  parameter int MAX_ELEMENTS = bis_pkg::MAX_ELEMENTS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  bis_in_if.sink    feed,
  bis_out_if.source sorted
);

  localparam int W = bis_pkg::VALUE_W;

  logic [W-1:0]            cell_value [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] cell_valid;
  logic [MAX_ELEMENTS-1:0] cell_gt;

  bis_pkg::chain_cmd_t    cmd;
  bis_pkg::chain_status_t status;
  logic                   in_fire;
  logic                   out_fire;
  logic                   draining;
  logic                   dropped;

  assign in_fire  = feed.valid && feed.ready;
  assign out_fire = sorted.valid && sorted.ready;

  assign status.full      = cell_valid[MAX_ELEMENTS-1];
  assign status.head_last = cell_valid[0] && !cell_valid[1];

  // Sequencer.
  bis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_fire  (in_fire),
    .in_last  (feed.last),
    .out_fire (out_fire),
    .status   (status),
    .cmd      (cmd),
    .in_ready (feed.ready),
    .draining (draining),
    .dropped  (dropped)
  );

  // Insertion chain; the head cell has an always-occupied, never-greater
  // left edge and the tail cell an empty right edge.
  for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
    logic [W-1:0] left_value;
    logic         left_valid;
    logic         left_gt;
    logic [W-1:0] right_value;
    logic         right_valid;

    if (i == 0) begin : g_head
      assign left_value = '0;
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_body
      assign left_value = cell_value[i-1];
      assign left_valid = cell_valid[i-1];
      assign left_gt    = cell_gt[i-1];
    end

    if (i == MAX_ELEMENTS - 1) begin : g_tail
      assign right_value = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[i+1];
      assign right_valid = cell_valid[i+1];
    end

    bis_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .value_in    (feed.value),
      .left_value  (left_value),
      .left_valid  (left_valid),
      .left_gt     (left_gt),
      .right_value (right_value),
      .right_valid (right_valid),
      .value       (cell_value[i]),
      .valid       (cell_valid[i]),
      .gt          (cell_gt[i])
    );
  end

  // Results leave straight from the head cell.
  assign sorted.valid        = draining && cell_valid[0];
  assign sorted.sorted_value = cell_value[0];
  assign sorted.end_of_run   = status.head_last;
  assign sorted.overflow     = dropped;

  // Occupied cells always form one block starting at the head.
  a_prefix: assert property (@(posedge clk) disable iff (rst)
    ((cell_valid + MAX_ELEMENTS'(1)) & cell_valid) == '0)
    else $error("occupied cells are not contiguous from the head");

  // The feed and the result channel are never open together.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    sorted.valid |-> !feed.ready)
    else $error("result offered while the feed is open");

  // Taking the final result reopens the feed and leaves the chain empty.
  a_reopen: assert property (@(posedge clk) disable iff (rst)
    out_fire && sorted.end_of_run |=> feed.ready && (cell_valid == '0))
    else $error("feed not reopened or chain not empty after the run");

  // A value that meets a full chain marks the run as overflowed.
  a_drop: assert property (@(posedge clk) disable iff (rst)
    in_fire && status.full |=> dropped && status.full)
    else $error("dropped value not flagged");

  // Closing the set always leaves at least one result to send.
  a_nonempty: assert property (@(posedge clk) disable iff (rst)
    in_fire && feed.last |=> sorted.valid)
    else $error("run closed without a result");

endmodule

FILE: verif/bounded_integer_sorter_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bounded integer sorter testbench
// Feeds sets of values, each closed by a last transaction, and checks the
// sorted runs that come back against a scoreboard that keeps its own sorted
// copy of each set. The scoreboard drops values beyond capacity and flags the
// run as overflowed. Directed sets cover the extremes of the value range,
// duplicates and ordered inputs. Random sets follow, mostly small ones with
// a few at and beyond capacity. The sender idles in bursts and the receiver
// stalls on its own pattern, with one long hold-off that backs up the feed.
// ----------------------------------------------------------------------------
module bounded_integer_sorter_test;

  typedef logic [bis_pkg::VALUE_W-1:0] value_t;

  localparam int CAPACITY = bis_pkg::MAX_ELEMENTS_DEF;
  localparam value_t VALUE_MAX = {bis_pkg::VALUE_W{1'b1}};
  localparam int RANDOM_ITEMS = 340;
  localparam int PRESSURE_AFTER = 30;
  localparam int PRESSURE_CYCLES = 300;

  // One expected sorted transaction.
  typedef struct packed {
    value_t value;
    logic   end_of_run;
    logic   overflow;
  } sorted_entry_t;

  // Scoreboard: keeps the open set in ascending order and queues the runs
  // that closed sets must produce.
  class sort_tracker;
    value_t             collected[$];
    logic               dropped;
    sorted_entry_t      awaited[$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        runs;
    int unsigned        overflow_runs;

    function new();
      dropped = 1'b0;
      mismatches = 0;
      checked = 0;
      runs = 0;
      overflow_runs = 0;
    endfunction

    // Place an accepted value after any equal ones; close the set on last.
    function void take_value(value_t v, logic closes);
      int pos;
      int n;
      if (collected.size() < CAPACITY) begin
        pos = collected.size();
        while (pos > 0 && collected[pos-1] > v) pos--;
        collected.insert(pos, v);
      end else begin
        dropped = 1'b1;
      end
      if (closes) begin
        n = collected.size();
        for (int i = 0; i < n; i++) begin
          awaited.push_back('{value: collected[i], end_of_run: (i == n - 1),
                              overflow: dropped});
        end
        runs++;
        if (dropped) overflow_runs++;
        collected.delete();
        dropped = 1'b0;
      end
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_sorted(value_t v, logic eor, logic ovf);
      sorted_entry_t want;
      if (awaited.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected: value=%0d end_of_run=%b overflow=%b",
                 $time, v, eor, ovf);
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (want.value !== v) begin
        mismatches++;
        $display("%0t: sorted_value mismatch: expected %0d, actual %0d",
                 $time, want.value, v);
      end
      if (want.end_of_run !== eor) begin
        mismatches++;
        $display("%0t: end_of_run mismatch: expected %b, actual %b",
                 $time, want.end_of_run, eor);
      end
      if (want.overflow !== ovf) begin
        mismatches++;
        $display("%0t: overflow mismatch: expected %b, actual %b",
                 $time, want.overflow, ovf);
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void finish();
      if (awaited.size() != 0) begin
        mismatches++;
        $display("%0t: %0d expected results never arrived", $time, awaited.size());
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  bis_in_if  feed_ch ();
  bis_out_if sorted_ch ();

  bounded_integer_sorter #(
    .MAX_ELEMENTS(CAPACITY)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .feed  (feed_ch),
    .sorted(sorted_ch)
  );

  sort_tracker tracker = new();

  int unsigned items_sent;
  int unsigned burst_left;
  bit          steady_feed;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("%0t: timeout, %0d results still expected", $time, tracker.pending());
    $display("Verification failed");
    $finish;
  end

  // Monitor: check results and note accepted inputs at each rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (sorted_ch.valid && sorted_ch.ready)
        tracker.check_sorted(sorted_ch.sorted_value, sorted_ch.end_of_run,
                             sorted_ch.overflow);
      if (feed_ch.valid && feed_ch.ready)
        tracker.take_value(feed_ch.value, feed_ch.last);
    end
  end

  // Receiver: stall pattern picked at random from four modes, with one long hold-off.
  initial begin
    int  mode;
    int  phase;
    bit  held_off;
    held_off = 1'b0;
    sorted_ch.ready = 1'b0;
    mode = 0;
    phase = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held_off && tracker.checked >= PRESSURE_AFTER) begin
        held_off = 1'b1;
        sorted_ch.ready = 1'b0;
        repeat (PRESSURE_CYCLES) @(negedge clk);
      end
      if (phase % 32 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: begin
          sorted_ch.ready = 1'b1;
        end
        1: begin
          sorted_ch.ready = 1'($urandom_range(0, 1));
        end
        2: begin
          sorted_ch.ready = (phase % 4 == 3);
        end
        default: begin
          sorted_ch.ready = ($urandom_range(0, 7) != 0);
        end
      endcase
      phase++;
      @(negedge clk);
    end
  end

  // Random value: small values for duplicates, full range, values near the
  // top, and single set bits.
  function automatic value_t pick_value();
    value_t v;
    case ($urandom_range(0, 3))
      0: begin
        v = value_t'($urandom_range(0, 7));
      end
      1: begin
        v = value_t'($urandom);
      end
      2: begin
        v = VALUE_MAX - value_t'($urandom_range(0, 3));
      end
      default: begin
        v = value_t'(1) << $urandom_range(0, bis_pkg::VALUE_W - 1);
      end
    endcase
    return v;
  endfunction

  // Offer one transaction, starting and ending just after a falling edge.
  task automatic feed_value(input value_t v, input logic closes);
    int gap;
    if (!steady_feed && burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        feed_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    if (burst_left > 0) burst_left--;
    feed_ch.valid = 1'b1;
    feed_ch.value = v;
    feed_ch.last = closes;
    do @(posedge clk); while (!feed_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_list(input value_t vals[$]);
    foreach (vals[i]) feed_value(vals[i], i == vals.size() - 1);
  endtask

  task automatic send_random_set(input int count);
    steady_feed = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < count; i++) feed_value(pick_value(), i == count - 1);
  endtask

  // Stimulus and end of run.
  initial begin
    value_t dir[$];
    int set_no;
    int count;
    items_sent = 0;
    burst_left = 0;
    steady_feed = 1'b0;
    feed_ch.valid = 1'b0;
    feed_ch.value = '0;
    feed_ch.last = 1'b0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed sets: single extremes, duplicates, mixed, ascending,
    // descending and alternating bit patterns.
    dir = '{'0};
    send_list(dir);
    dir = '{VALUE_MAX};
    send_list(dir);
    dir = '{31'd9, 31'd9, 31'd9};
    send_list(dir);
    dir = '{VALUE_MAX, 31'd5, 31'd0, VALUE_MAX, 31'd0, 31'd5};
    send_list(dir);
    dir = '{31'd1, 31'd2, 31'd3, 31'd4};
    send_list(dir);
    dir = '{31'd40, 31'd30, 31'd20, 31'd10};
    send_list(dir);
    dir = '{31'h2AAAAAAA, 31'h55555555};
    send_list(dir);

    // Random sets: mostly small, a full set, a set whose last value is
    // dropped, and a few beyond capacity.
    set_no = 0;
    while (items_sent < RANDOM_ITEMS + 21) begin
      if (set_no == 1)
        count = CAPACITY;
      else if (set_no == 4)
        count = CAPACITY + 1;
      else if (set_no == 7)
        count = CAPACITY + 5;
      else if ($urandom_range(0, 24) == 0)
        count = $urandom_range(CAPACITY - 2, CAPACITY + 3);
      else
        count = $urandom_range(1, 8);
      send_random_set(count);
      set_no++;
    end
    feed_ch.valid = 1'b0;

    // Drain and let any stray result show up.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2 * CAPACITY + 10) @(posedge clk);
    tracker.finish();

    $display("Sent %0d values in %0d sets, %0d of them overflowed.",
             items_sent, tracker.runs, tracker.overflow_runs);
    $display("Checked %0d sorted results under random stalls and one long hold-off.",
             tracker.checked);
    if (tracker.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
